FILE: sv/lcp_pkg.sv
// Shared types and constants for the color list line parser.
// No dependencies; every other file imports this package.
package lcp_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 32;
  localparam int unsigned NUM_COMPONENTS = 3;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned DECIMAL_BASE   = 10;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] LEVEL_MAX  = 8'hFF;

  typedef enum logic [1:0] {
    TOK_SLASH,
    TOK_COMMA,
    TOK_DIGIT,
    TOK_OTHER
  } tok_kind_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [4:0] pixel_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       pixel_valid;
    logic [5:0] pixel_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
    logic       eol;
  } token_t;

endpackage

FILE: sv/lcp_front.sv
// Front end: classifies one input character into a parser token.
// Depends on lcp_pkg.
module lcp_front import lcp_pkg::*; (
  input  in_item_t item_i,
  output token_t   token_o
);

  always_comb begin
    token_o.eol   = item_i.end_of_line;
    token_o.digit = item_i.char_code[3:0];
    priority if (item_i.char_code == CHAR_SLASH) begin
      token_o.kind = TOK_SLASH;
    end else if (item_i.char_code == CHAR_COMMA) begin
      token_o.kind = TOK_COMMA;
    end else if (item_i.char_code >= CHAR_ZERO && item_i.char_code <= CHAR_NINE) begin
      token_o.kind = TOK_DIGIT;
    end else begin
      token_o.kind = TOK_OTHER;
    end
  end

endmodule

FILE: sv/lcp_queue.sv
// Short token queue between the classifier and the parser back end.
// Depends on lcp_pkg.
module lcp_queue import lcp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t push_data_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   not_empty_o,
  output token_t pop_data_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  token_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o      = (count_q == CntW'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/lcp_back.sv
// Back end: parser state, digit fold and the registered result stage.
// Depends on lcp_pkg.
module lcp_back import lcp_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      tok_valid_i,
  input  token_t    tok_i,
  output logic      tok_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned PosW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned ExtW = (PosW + 1 > 6) ? PosW + 1 : 6;
  localparam int unsigned LastComp = NUM_COMPONENTS - 1;

  logic [7:0]      comp_q [NUM_COMPONENTS];
  logic [7:0]      comp_d [NUM_COMPONENTS];
  logic [7:0]      res_comp [NUM_COMPONENTS];
  logic [1:0]      idx_q, idx_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            in_num_q, in_num_d;
  logic            seen_q, seen_d;
  logic            stop_q, stop_d;
  logic            out_valid_q;
  out_item_t       out_q, res;

  logic            take, advance, slash_emit, seen_upd, pix_valid, emit;
  logic [7:0]      comp_sel;
  logic [11:0]     fold;
  logic [7:0]      fold_sat;
  logic [ExtW-1:0] pos_ext;

  assign advance   = !out_valid_q || !out_stall_i;
  assign take      = tok_valid_i && advance;
  assign tok_pop_o = take;

  // Digit fold: value * 10 + digit, clamp at full scale.
  always_comb begin
    comp_sel = comp_q[0];
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (idx_q == 2'(i)) comp_sel = comp_q[i];
    end
    fold     = in_num_q ? (12'(comp_sel) * 12'(DECIMAL_BASE) + 12'(tok_i.digit))
                        : 12'(tok_i.digit);
    fold_sat = (fold > 12'(LEVEL_MAX)) ? LEVEL_MAX : fold[7:0];
  end

  always_comb begin
    comp_d     = comp_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    in_num_d   = in_num_q;
    seen_d     = seen_q;
    stop_d     = stop_q;
    slash_emit = 1'b0;
    if (!stop_q) begin
      unique case (tok_i.kind)
        TOK_SLASH: begin
          slash_emit = 1'b1;
          pos_d      = pos_q + 1'b1;
          for (int i = 0; i < NUM_COMPONENTS; i++) comp_d[i] = '0;
          idx_d      = '0;
          in_num_d   = 1'b0;
          seen_d     = 1'b0;
          if (pos_d == PosW'(MAX_PIXELS)) stop_d = 1'b1;
        end
        TOK_COMMA: begin
          in_num_d = 1'b0;
          if (idx_q == 2'(LastComp)) begin
            stop_d = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        TOK_DIGIT: begin
          for (int i = 0; i < NUM_COMPONENTS; i++) begin
            if (idx_q == 2'(i)) comp_d[i] = fold_sat;
          end
          in_num_d = 1'b1;
          seen_d   = 1'b1;
        end
        default: begin
          in_num_d = 1'b0;
        end
      endcase
    end

    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      res_comp[i] = slash_emit ? comp_q[i] : comp_d[i];
    end
    seen_upd  = seen_d;
    emit      = slash_emit || tok_i.eol;
    pix_valid = slash_emit || (seen_upd && (pos_q < PosW'(MAX_PIXELS)));
    pos_ext   = ExtW'(pos_q);

    res.last        = tok_i.eol;
    res.pixel_valid = pix_valid;
    res.pixel_index = pix_valid ? pos_ext[4:0] : '0;
    res.red_level   = pix_valid ? res_comp[1] : '0;
    res.green_level = pix_valid ? res_comp[0] : '0;
    res.blue_level  = pix_valid ? res_comp[2] : '0;
    res.pixel_count = pix_valid ? 6'(pos_ext + 1'b1) : pos_ext[5:0];

    // Line end returns the parser to its reset state.
    if (tok_i.eol) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) comp_d[i] = '0;
      idx_d    = '0;
      pos_d    = '0;
      in_num_d = 1'b0;
      seen_d   = 1'b0;
      stop_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) comp_q[i] <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      in_num_q    <= 1'b0;
      seen_q      <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        comp_q      <= comp_d;
        idx_q       <= idx_d;
        pos_q       <= pos_d;
        in_num_q    <= in_num_d;
        seen_q      <= seen_d;
        stop_q      <= stop_d;
        out_valid_q <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/led_color_list_parser_top.sv
// Top level of the color list line parser: front classifier, token queue, back end.
// Depends on lcp_pkg, lcp_front, lcp_queue and lcp_back.
//
// Usage:
//   Feed a line such as "12,200,7/0,0,255" one character per input beat on
//   in_data_i, with end_of_line set on the final character. Each slash, unless
//   parsing has stopped, yields one pixel beat; the end of the line yields one
//   beat with last set, carrying the final pixel (if digits were pending) and
//   the count. Red comes from the second number of a group, green from the first.
// Channels:
//   Input  in_valid_i / in_stall_o / in_data_i   (beat when valid && !stall)
//   Output out_valid_o / out_stall_i / out_data_o
// Path: an accepted character's token is held in the token queue; the result
//   it yields is captured in the result register.
// Throughput: one character per cycle while the receiver does not stall; the
//   digit fold (multiply by ten, add, clamp) in the back end is combinational.
// Stall: when the receiver stalls, the result register holds its beat and the
//   back end halts; the queue absorbs up to two more characters, then
//   in_stall_o rises until the receiver drains.
// Reset: clears all parser state and empties the queue; the first line
//   starts at pixel 0.
module led_color_list_parser_top import lcp_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  token_t front_tok, queue_tok;
  logic   queue_full, queue_not_empty, back_pop;

  // Classify the incoming character.
  lcp_front u_front (
    .item_i  (in_data_i),
    .token_o (front_tok)
  );

  // Hold classified tokens so front and back stall independently.
  lcp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_tok),
    .pop_i       (back_pop),
    .full_o      (queue_full),
    .not_empty_o (queue_not_empty),
    .pop_data_o  (queue_tok)
  );

  assign in_stall_o = queue_full;

  // Advance the parser and register the result beat.
  lcp_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (queue_not_empty),
    .tok_i       (queue_tok),
    .tok_pop_o   (back_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A beat without a pixel only closes a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.pixel_valid) |-> out_data_o.last)
    else $error("pixel-less result beat without last");

  // A beat without a pixel carries zero index and levels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.pixel_valid) |->
      (out_data_o.pixel_index == '0 && out_data_o.red_level == '0 &&
       out_data_o.green_level == '0 && out_data_o.blue_level == '0))
    else $error("pixel-less result beat carries pixel data");

  // A pixel beat counts its own position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pixel_valid) |->
      (out_data_o.pixel_count[4:0] == 5'(out_data_o.pixel_index + 1'b1)))
    else $error("pixel count does not match pixel index");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pop |-> queue_not_empty)
    else $error("token popped from empty queue");

endmodule
